// ----- src/assert_macros.svh -----
// Assertion macros used by the pixel unpacker back end (pfr_back).
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define PFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pfr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the pixel format to rgb24 unit.
// No dependencies.
package pfr_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic [2:0] REG_DEPTH  = 3'd0;
  localparam logic [2:0] REG_ALPHA  = 3'd1;
  localparam logic [2:0] REG_CUSTOM = 3'd2;
  localparam logic [2:0] REG_RMASK  = 3'd3;
  localparam logic [2:0] REG_GMASK  = 3'd4;
  localparam logic [2:0] REG_BMASK  = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;

  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_4  = 3'd1,
    DEPTH_8  = 3'd2,
    DEPTH_16 = 3'd3,
    DEPTH_24 = 3'd4,
    DEPTH_32 = 3'd5,
    DEPTH_64 = 3'd6
  } depth_e;

  localparam logic [1:0] ALPHA_NONE = 2'd0;
  localparam logic [1:0] ALPHA_RGBA = 2'd1;
  localparam logic [1:0] ALPHA_GREY = 2'd2;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_PAL  = 1'b1;

  localparam logic [31:0] MASK16_R = 32'h0000_7C00;
  localparam logic [31:0] MASK16_G = 32'h0000_03E0;
  localparam logic [31:0] MASK16_B = 32'h0000_001F;
  localparam logic [31:0] MASK32_R = 32'h00FF_0000;
  localparam logic [31:0] MASK32_G = 32'h0000_FF00;
  localparam logic [31:0] MASK32_B = 32'h0000_00FF;

  localparam logic [2:0]  RST_DEPTH  = DEPTH_8;
  localparam logic [1:0]  RST_ALPHA  = ALPHA_NONE;
  localparam logic        RST_CUSTOM = 1'b0;
  localparam logic [12:0] RST_WIDTH  = 13'd1;

  typedef enum logic [3:0] {
    KIND_PAL_WR,
    KIND_PACK1,
    KIND_PACK4,
    KIND_INDEX8,
    KIND_MASK,
    KIND_GREY8,
    KIND_GREY16,
    KIND_RGBA,
    KIND_PASS24,
    KIND_PASS64
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [63:0]  data;
    logic [7:0]   pal_index;
    logic [23:0]  pal_color;
  } item_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [31:0]      rmask;
    logic [31:0]      gmask;
    logic [31:0]      bmask;
    logic [4:0]       rtop;
    logic [4:0]       gtop;
    logic [4:0]       btop;
  } cfg_t;

  // position of the highest set bit, 0 for an empty mask
  function automatic logic [4:0] top_bit(input logic [31:0] mask);
    logic [4:0] pos;
    pos = '0;
    for (int b = 0; b < 32; b++) begin
      if (mask[b]) begin
        pos = 5'(b);
      end
    end
    return pos;
  endfunction

endpackage

// ----- src/pixel_format_to_rgb24_unit.sv -----
`timescale 1ns / 1ps
// Bitmap pixel unpacker: source words in, 24-bit blue/green/red pixels out.
// Depends on pfr_pkg, pfr_front, pfr_fifo and pfr_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word: func_i=0 is a
//   source data word, func_i=1 writes palette_color_i at palette_index_i.
//   Output channel (out_valid_o/out_ready_i) carries one pixel per word,
//   with row_end_o on the last pixel of a row and last_o on the last pixel
//   produced by a source word.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// Timing:
//   A word passes the queue, then its pixels the output register. One
//   pixel per cycle sustained while out_ready_i is high. An 8-bit or
//   16/24/32/64-bit word gives one pixel, a 1-bit word up to 8, a 4-bit
//   word up to 2, via the single palette read port (one lookup a cycle).
// Reset:
//   Registers take their defaults, column count clears, queue empties.
//   Palette contents are undefined until written.
// Stall:
//   The output register holds; a two-word queue keeps taking words until
//   full, then in_ready_o drops.
module pixel_format_to_rgb24_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [63:0] data_unit_i,
  input  logic [7:0]  palette_index_i,
  input  logic [23:0] palette_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_red_o,
  output logic        row_end_o,
  output logic        last_o
);

  logic           q_push, q_ready, q_valid, q_pop;
  pfr_pkg::item_t push_item, head_item;
  pfr_pkg::cfg_t  cfg;

  pfr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .data_unit_i     (data_unit_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_item_o        (push_item),
    .cfg_o           (cfg)
  );

  pfr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (q_pop)
  );

  pfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o),
    .row_end_o   (row_end_o),
    .last_o      (last_o)
  );

endmodule

// ----- src/pfr_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pfr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pfr_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, derived mask setup and word classification.
// Depends on pfr_pkg.
module pfr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [63:0]         data_unit_i,
  input  logic [7:0]          palette_index_i,
  input  logic [23:0]         palette_color_i,
  input  logic                q_ready_i,
  output logic                q_push_o,
  output pfr_pkg::item_t      q_item_o,
  output pfr_pkg::cfg_t       cfg_o
);

  logic [2:0]  depth_q;
  logic [1:0]  alpha_q;
  logic        custom_q;
  logic [31:0] rmask_q, gmask_q, bmask_q;
  logic [12:0] img_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= pfr_pkg::RST_DEPTH;
      alpha_q     <= pfr_pkg::RST_ALPHA;
      custom_q    <= pfr_pkg::RST_CUSTOM;
      rmask_q     <= pfr_pkg::MASK32_R;
      gmask_q     <= pfr_pkg::MASK32_G;
      bmask_q     <= pfr_pkg::MASK32_B;
      img_width_q <= pfr_pkg::RST_WIDTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfr_pkg::REG_DEPTH:  depth_q     <= cfg_wdata_i[2:0];
        pfr_pkg::REG_ALPHA:  alpha_q     <= cfg_wdata_i[1:0];
        pfr_pkg::REG_CUSTOM: custom_q    <= cfg_wdata_i[0];
        pfr_pkg::REG_RMASK:  rmask_q     <= cfg_wdata_i;
        pfr_pkg::REG_GMASK:  gmask_q     <= cfg_wdata_i;
        pfr_pkg::REG_BMASK:  bmask_q     <= cfg_wdata_i;
        pfr_pkg::REG_WIDTH:  img_width_q <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // derived setup, registered off the item path
  logic [31:0]               rm_d, gm_d, bm_d;
  logic [pfr_pkg::WID_W-1:0] width_d;
  pfr_pkg::cfg_t             cfg_q;

  always_comb begin
    if (custom_q) begin
      rm_d = rmask_q;
      gm_d = gmask_q;
      bm_d = bmask_q;
    end else if (depth_q == pfr_pkg::DEPTH_16) begin
      rm_d = pfr_pkg::MASK16_R;
      gm_d = pfr_pkg::MASK16_G;
      bm_d = pfr_pkg::MASK16_B;
    end else begin
      rm_d = pfr_pkg::MASK32_R;
      gm_d = pfr_pkg::MASK32_G;
      bm_d = pfr_pkg::MASK32_B;
    end
    if (img_width_q == '0) begin
      width_d = pfr_pkg::WID_W'(1);
    end else if (32'(img_width_q) > pfr_pkg::MAX_WIDTH) begin
      width_d = pfr_pkg::WID_W'(pfr_pkg::MAX_WIDTH);
    end else begin
      width_d = pfr_pkg::WID_W'(img_width_q);
    end
  end

  always_ff @(posedge clk_i) begin
    cfg_q.width <= width_d;
    cfg_q.rmask <= rm_d;
    cfg_q.gmask <= gm_d;
    cfg_q.bmask <= bm_d;
    cfg_q.rtop  <= pfr_pkg::top_bit(rm_d);
    cfg_q.gtop  <= pfr_pkg::top_bit(gm_d);
    cfg_q.btop  <= pfr_pkg::top_bit(bm_d);
  end

  assign cfg_o = cfg_q;

  // classification
  pfr_pkg::item_t item;
  logic           drop;

  always_comb begin
    item.kind      = pfr_pkg::KIND_INDEX8;
    item.data      = data_unit_i;
    item.pal_index = palette_index_i;
    item.pal_color = palette_color_i;
    drop           = 1'b0;
    if (func_i == pfr_pkg::FUNC_PAL) begin
      item.kind = pfr_pkg::KIND_PAL_WR;
    end else begin
      case (depth_q)
        pfr_pkg::DEPTH_1:  item.kind = pfr_pkg::KIND_PACK1;
        pfr_pkg::DEPTH_4:  item.kind = pfr_pkg::KIND_PACK4;
        pfr_pkg::DEPTH_8:  item.kind = pfr_pkg::KIND_INDEX8;
        pfr_pkg::DEPTH_16: begin
          item.data = 64'(data_unit_i[15:0]);
          item.kind = (alpha_q == pfr_pkg::ALPHA_GREY) ? pfr_pkg::KIND_GREY8
                                                       : pfr_pkg::KIND_MASK;
        end
        pfr_pkg::DEPTH_24: item.kind = pfr_pkg::KIND_PASS24;
        pfr_pkg::DEPTH_32: begin
          item.data = 64'(data_unit_i[31:0]);
          if (alpha_q == pfr_pkg::ALPHA_RGBA) begin
            item.kind = pfr_pkg::KIND_RGBA;
          end else if (alpha_q == pfr_pkg::ALPHA_GREY) begin
            item.kind = pfr_pkg::KIND_GREY16;
          end else begin
            item.kind = pfr_pkg::KIND_MASK;
          end
        end
        pfr_pkg::DEPTH_64: item.kind = pfr_pkg::KIND_PASS64;
        default:           drop = 1'b1;
      endcase
    end
  end

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i && !drop;
  assign q_item_o   = item;

endmodule

// ----- src/pfr_fifo.sv -----
`timescale 1ns / 1ps
// Short word queue between the front end and the pixel back end.
// Depends on pfr_pkg.
module pfr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pfr_pkg::item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  output pfr_pkg::item_t item_o,
  input  logic           pop_i
);

  pfr_pkg::item_t             mem_q [pfr_pkg::Q_DEPTH];
  logic [pfr_pkg::Q_AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [pfr_pkg::Q_CW-1:0]   cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign ready_o = (32'(cnt_q) < pfr_pkg::Q_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (32'(wr_q) == pfr_pkg::Q_DEPTH - 1) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (32'(rd_q) == pfr_pkg::Q_DEPTH - 1) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- src/pfr_back.sv -----
`timescale 1ns / 1ps
// Back end: unpacks queued words into pixels, palette lookup, output register.
// Depends on pfr_pkg, pfr_ram and assert_macros.svh.
`include "assert_macros.svh"
module pfr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  pfr_pkg::item_t q_item_i,
  output logic           q_pop_o,
  input  pfr_pkg::cfg_t  cfg_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_blue_o,
  output logic [7:0]     out_green_o,
  output logic [7:0]     out_red_o,
  output logic           row_end_o,
  output logic           last_o
);

  function automatic logic [7:0] mask_chan(input logic [31:0] p,
                                           input logic [31:0] m,
                                           input logic [4:0]  top);
    logic [38:0] t;
    t = {p & m, 7'b0} >> top;
    return t[7:0];
  endfunction

  logic [2:0]                 k_q, k_d, maxk;
  logic [pfr_pkg::COL_W-1:0]  col_q, col_d, col_eff;
  logic                       rend, last;
  logic                       is_pal_wr, pix, adv_pix;
  logic                       packed_kind;
  logic                       use_pal, idx_oob, wr_oob;
  logic [7:0]                 pal_idx;
  logic [7:0]                 b_d, g_d, r_d, a8;
  logic [15:0]                prod_b, prod_g, prod_r;
  logic [31:0]                prod_grey;
  logic [63:0]                data;
  pfr_pkg::kind_e             kind;

  assign kind        = q_item_i.kind;
  assign data        = q_item_i.data;
  assign is_pal_wr   = (kind == pfr_pkg::KIND_PAL_WR);
  assign packed_kind = (kind == pfr_pkg::KIND_PACK1) || (kind == pfr_pkg::KIND_PACK4);

  // row position
  assign col_eff = (pfr_pkg::WID_W'(col_q) >= cfg_i.width) ? '0 : col_q;
  assign rend    = (pfr_pkg::WID_W'(col_eff) + pfr_pkg::WID_W'(1) >= cfg_i.width);
  assign last    = rend || (k_q == maxk);

  always_comb begin
    maxk    = 3'd0;
    use_pal = 1'b0;
    pal_idx = data[7:0];
    case (kind)
      pfr_pkg::KIND_PACK1: begin
        maxk    = 3'd7;
        use_pal = 1'b1;
        pal_idx = {7'b0, data[3'd7 - k_q]};
      end
      pfr_pkg::KIND_PACK4: begin
        maxk    = 3'd1;
        use_pal = 1'b1;
        pal_idx = (k_q == 3'd0) ? {4'b0, data[7:4]} : {4'b0, data[3:0]};
      end
      pfr_pkg::KIND_INDEX8: use_pal = 1'b1;
      default: ;
    endcase
  end

  assign idx_oob = (32'(pal_idx) >= pfr_pkg::PAL_DEPTH);
  assign wr_oob  = (32'(q_item_i.pal_index) >= pfr_pkg::PAL_DEPTH);

  // direct color paths
  assign a8        = (kind == pfr_pkg::KIND_GREY8) ? data[15:8] : data[31:24];
  assign prod_b    = 16'(data[7:0]) * 16'(a8);
  assign prod_g    = 16'(data[15:8]) * 16'(data[31:24]);
  assign prod_r    = 16'(data[23:16]) * 16'(data[31:24]);
  assign prod_grey = 32'(data[15:0]) * 32'(data[31:16]);

  always_comb begin
    b_d = '0;
    g_d = '0;
    r_d = '0;
    case (kind)
      pfr_pkg::KIND_MASK: begin
        b_d = mask_chan(data[31:0], cfg_i.bmask, cfg_i.btop);
        g_d = mask_chan(data[31:0], cfg_i.gmask, cfg_i.gtop);
        r_d = mask_chan(data[31:0], cfg_i.rmask, cfg_i.rtop);
      end
      pfr_pkg::KIND_GREY8: begin
        b_d = prod_b[15:8];
        g_d = prod_b[15:8];
        r_d = prod_b[15:8];
      end
      pfr_pkg::KIND_GREY16: begin
        b_d = prod_grey[31:24];
        g_d = prod_grey[31:24];
        r_d = prod_grey[31:24];
      end
      pfr_pkg::KIND_RGBA: begin
        b_d = prod_b[15:8];
        g_d = prod_g[15:8];
        r_d = prod_r[15:8];
      end
      pfr_pkg::KIND_PASS24: begin
        b_d = data[7:0];
        g_d = data[15:8];
        r_d = data[23:16];
      end
      pfr_pkg::KIND_PASS64: begin
        b_d = data[7:0];
        g_d = data[23:16];
        r_d = data[39:32];
      end
      default: ;
    endcase
  end

  // output stage
  logic       s2_valid_q;
  logic       s2_pal_q, s2_zero_q, s2_rend_q, s2_last_q;
  logic [7:0] s2_b_q, s2_g_q, s2_r_q;
  logic       ram_we, ram_re;
  logic [23:0] ram_rdata;

  assign pix     = q_valid_i && !is_pal_wr;
  assign adv_pix = pix && (!s2_valid_q || out_ready_i);
  assign q_pop_o = (q_valid_i && is_pal_wr) || (adv_pix && last);
  assign ram_we  = q_valid_i && is_pal_wr && !wr_oob;
  assign ram_re  = adv_pix && use_pal;

  pfr_ram #(
    .WIDTH (24),
    .DEPTH (pfr_pkg::PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_item_i.pal_index[pfr_pkg::PAL_AW-1:0]),
    .wdata_i (q_item_i.pal_color),
    .re_i    (ram_re),
    .raddr_i (pal_idx[pfr_pkg::PAL_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    k_d   = k_q;
    col_d = col_q;
    if (adv_pix) begin
      k_d   = last ? 3'd0 : k_q + 3'd1;
      col_d = rend ? '0 : pfr_pkg::COL_W'(pfr_pkg::WID_W'(col_eff) + pfr_pkg::WID_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      col_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      k_q   <= k_d;
      col_q <= col_d;
      if (adv_pix) begin
        s2_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_pix) begin
      s2_pal_q  <= use_pal;
      s2_zero_q <= idx_oob;
      s2_rend_q <= rend;
      s2_last_q <= last;
      s2_b_q    <= b_d;
      s2_g_q    <= g_d;
      s2_r_q    <= r_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_blue_o  = s2_pal_q ? (s2_zero_q ? '0 : ram_rdata[7:0])   : s2_b_q;
  assign out_green_o = s2_pal_q ? (s2_zero_q ? '0 : ram_rdata[15:8])  : s2_g_q;
  assign out_red_o   = s2_pal_q ? (s2_zero_q ? '0 : ram_rdata[23:16]) : s2_r_q;
  assign row_end_o   = s2_rend_q;
  assign last_o      = s2_last_q;

  `PFR_ASSERT(a_k_unpacked, (q_valid_i && !packed_kind) |-> (k_q == 3'd0), "stray pixel index")
  `PFR_ASSERT(a_k_range, q_valid_i |-> (k_q <= maxk), "pixel index beyond word")
  `PFR_ASSERT_NEXT(a_rd_lands, ram_re, s2_valid_q && s2_pal_q, "palette read lost")

endmodule

// ----- sim/pixel_format_to_rgb24_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pixel_format_to_rgb24_unit: random and directed words
// against a built-in pixel predictor, with random idling on both channels.
// Depends on pfr_pkg and the unit RTL.
module pixel_format_to_rgb24_unit_test;

  localparam int CLK_PERIOD = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_WORDS = 30;
  localparam int FINAL_WORDS = 32;
  localparam logic [2:0] DEPTH_UNKNOWN = 3'd7;
  localparam logic [1:0] ALPHA_SPARE = 2'd3;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [63:0] data_unit_i;
  logic [7:0]  palette_index_i;
  logic [23:0] palette_color_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_blue_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_red_o;
  logic        row_end_o;
  logic        last_o;

  // predictor state
  logic [23:0] pal_mem [pfr_pkg::PAL_DEPTH];
  int          col_cnt;
  logic [2:0]  cur_depth;
  logic [1:0]  cur_alpha;
  logic        cur_custom;
  logic [31:0] cur_rmask;
  logic [31:0] cur_gmask;
  logic [31:0] cur_bmask;
  logic [12:0] cur_width;

  pixel_t expected_pixels[$];
  pixel_t want;
  int     errors = 0;
  int     stuck_cycles = 0;
  int     stall_left = 0;
  int     random_words = 0;
  bit     idle_on = 1'b1;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  pixel_format_to_rgb24_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .data_unit_i    (data_unit_i),
    .palette_index_i(palette_index_i),
    .palette_color_i(palette_color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_blue_o     (out_blue_o),
    .out_green_o    (out_green_o),
    .out_red_o      (out_red_o),
    .row_end_o      (row_end_o),
    .last_o         (last_o)
  );

  function automatic logic [7:0] mask_chan(logic [31:0] pix, logic [31:0] mask);
    logic [31:0] v;
    int top;
    if (mask == '0) return '0;
    v = pix & mask;
    top = 0;
    for (int b = 0; b < 32; b++) if (mask[b]) top = b;
    v = (top > 7) ? v >> (top - 7) : v << (7 - top);
    return v[7:0];
  endfunction

  function automatic void predict_pixels(logic func, logic [63:0] d, logic [7:0] idx,
                                         logic [23:0] color);
    logic [23:0] px [8];
    logic [31:0] rm, gm, bm, w;
    logic [15:0] t;
    int wd, n;
    logic rend;
    pixel_t pix;
    if (func == pfr_pkg::FUNC_PAL) begin
      pal_mem[idx] = color;
      return;
    end
    if (cur_depth == DEPTH_UNKNOWN) return;
    wd = cur_width;
    if (wd == 0) wd = 1;
    else if (wd > pfr_pkg::MAX_WIDTH) wd = pfr_pkg::MAX_WIDTH;
    if (col_cnt >= wd) col_cnt = 0;
    n = 1;
    if (cur_custom) begin
      rm = cur_rmask; gm = cur_gmask; bm = cur_bmask;
    end else if (cur_depth == pfr_pkg::DEPTH_16) begin
      rm = pfr_pkg::MASK16_R; gm = pfr_pkg::MASK16_G; bm = pfr_pkg::MASK16_B;
    end else begin
      rm = pfr_pkg::MASK32_R; gm = pfr_pkg::MASK32_G; bm = pfr_pkg::MASK32_B;
    end
    case (cur_depth)
      pfr_pkg::DEPTH_1: begin
        n = (wd - col_cnt < 8) ? wd - col_cnt : 8;
        for (int k = 0; k < n; k++) px[k] = pal_mem[{7'd0, d[7 - k]}];
      end
      pfr_pkg::DEPTH_4: begin
        n = (wd - col_cnt < 2) ? wd - col_cnt : 2;
        px[0] = pal_mem[{4'd0, d[7:4]}];
        px[1] = pal_mem[{4'd0, d[3:0]}];
      end
      pfr_pkg::DEPTH_8: px[0] = pal_mem[d[7:0]];
      pfr_pkg::DEPTH_16: begin
        if (cur_alpha == pfr_pkg::ALPHA_GREY) begin
          t = d[7:0] * d[15:8];
          px[0] = {3{t[15:8]}};
        end else begin
          px[0] = {mask_chan({16'd0, d[15:0]}, rm), mask_chan({16'd0, d[15:0]}, gm),
                   mask_chan({16'd0, d[15:0]}, bm)};
        end
      end
      pfr_pkg::DEPTH_24: px[0] = d[23:0];
      pfr_pkg::DEPTH_32: begin
        if (cur_alpha == pfr_pkg::ALPHA_RGBA) begin
          t = d[7:0] * d[31:24];
          px[0][7:0] = t[15:8];
          t = d[15:8] * d[31:24];
          px[0][15:8] = t[15:8];
          t = d[23:16] * d[31:24];
          px[0][23:16] = t[15:8];
        end else if (cur_alpha == pfr_pkg::ALPHA_GREY) begin
          w = d[15:0] * d[31:16];
          px[0] = {3{w[31:24]}};
        end else begin
          px[0] = {mask_chan(d[31:0], rm), mask_chan(d[31:0], gm), mask_chan(d[31:0], bm)};
        end
      end
      pfr_pkg::DEPTH_64: px[0] = {d[39:32], d[23:16], d[7:0]};
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      rend = (col_cnt + 1 >= wd);
      pix.blue = px[k][7:0];
      pix.green = px[k][15:8];
      pix.red = px[k][23:16];
      pix.row_end = rend;
      pix.last = (k == n - 1);
      expected_pixels.push_back(pix);
      col_cnt = rend ? 0 : col_cnt + 1;
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_mask();
    logic [63:0] field;
    int lo, len;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return '0;
      default: begin
        lo = $urandom_range(0, 31);
        len = $urandom_range(1, 32 - lo);
        field = ((64'd1 << len) - 64'd1) << lo;
        return field[31:0];
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
    end
  endtask

  task automatic send_word(logic func, logic [63:0] d, logic [7:0] idx, logic [23:0] color);
    int gap;
    if (idle_on && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    data_unit_i <= d;
    palette_index_i <= idx;
    palette_color_i <= color;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixels(func, d, idx, color);
  endtask

  task automatic send_data(logic [63:0] d);
    send_word(pfr_pkg::FUNC_DATA, d, 8'($urandom), 24'($urandom));
  endtask

  // wait until every pixel is out and trailing words have drained
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      pfr_pkg::REG_DEPTH: cur_depth = val[2:0];
      pfr_pkg::REG_ALPHA: cur_alpha = val[1:0];
      pfr_pkg::REG_CUSTOM: cur_custom = val[0];
      pfr_pkg::REG_RMASK: cur_rmask = val;
      pfr_pkg::REG_GMASK: cur_gmask = val;
      pfr_pkg::REG_BMASK: cur_bmask = val;
      pfr_pkg::REG_WIDTH: cur_width = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(logic [2:0] depth, logic [1:0] alpha, logic custom,
                          logic [12:0] width);
    logic [31:0] junk;
    quiesce();
    junk = $urandom;
    set_reg(pfr_pkg::REG_DEPTH, {junk[31:3], depth});
    junk = $urandom;
    set_reg(pfr_pkg::REG_ALPHA, {junk[31:2], alpha});
    junk = $urandom;
    set_reg(pfr_pkg::REG_CUSTOM, {junk[31:1], custom});
    junk = $urandom;
    set_reg(pfr_pkg::REG_WIDTH, {junk[31:13], width});
  endtask

  task automatic set_masks(logic [31:0] rm, logic [31:0] gm, logic [31:0] bm);
    set_reg(pfr_pkg::REG_RMASK, rm);
    set_reg(pfr_pkg::REG_GMASK, gm);
    set_reg(pfr_pkg::REG_BMASK, bm);
  endtask

  task automatic test_palette_load();
    logic [23:0] color;
    for (int i = 0; i < pfr_pkg::PAL_DEPTH; i++) begin
      color = (i == 0) ? 24'hFF_FFFF :
              (i == pfr_pkg::PAL_DEPTH - 1) ? 24'h00_0000 : 24'($urandom);
      send_word(pfr_pkg::FUNC_PAL, rand64(), 8'(i), color);
    end
  endtask

  // registers untouched since reset: 8-bit palette, one pixel per row
  task automatic test_reset_state();
    send_data({56'hFFFF_FFFF_FFFF_FF, 8'h00});
    send_data({56'h0, 8'hFF});
  endtask

  task automatic test_packed_depths();
    set_mode(pfr_pkg::DEPTH_1, pfr_pkg::ALPHA_NONE, 1'b0, 13'd11);
    send_data(64'h5A);
    send_data(64'hFF);
    set_mode(pfr_pkg::DEPTH_4, pfr_pkg::ALPHA_NONE, 1'b0, 13'd3);
    send_data(64'hF0);
    send_data(64'h0F);
    send_data(64'h3C);
  endtask

  task automatic test_mask_channels();
    set_mode(pfr_pkg::DEPTH_16, pfr_pkg::ALPHA_NONE, 1'b0, 13'd5);
    send_data({48'hFFFF_FFFF_FFFF, 16'h0000});
    send_data(64'hFFFF);
    set_mode(pfr_pkg::DEPTH_32, pfr_pkg::ALPHA_NONE, 1'b1, 13'd5);
    send_data(64'h00FF_8001);
    quiesce();
    set_masks(32'h8000_0000, 32'h0000_0003, 32'h0000_0000);
    send_data(64'h8000_0002);
    set_mode(pfr_pkg::DEPTH_16, pfr_pkg::ALPHA_RGBA, 1'b1, 13'd5);
    set_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
    send_data(64'hFFFF);
  endtask

  task automatic test_alpha_blend();
    set_mode(pfr_pkg::DEPTH_32, pfr_pkg::ALPHA_RGBA, 1'b0, 13'd4);
    send_data(64'hFFFF_FFFF);
    send_data(64'h80FF_4020);
    set_mode(pfr_pkg::DEPTH_32, pfr_pkg::ALPHA_GREY, 1'b0, 13'd4);
    send_data(64'hFFFF_FFFF);
    set_mode(pfr_pkg::DEPTH_16, pfr_pkg::ALPHA_GREY, 1'b0, 13'd4);
    send_data(64'hFFFF);
    set_mode(pfr_pkg::DEPTH_32, ALPHA_SPARE, 1'b0, 13'd4);
    send_data(64'h1234_5678);
  endtask

  task automatic test_passthrough();
    set_mode(pfr_pkg::DEPTH_24, pfr_pkg::ALPHA_NONE, 1'b0, 13'd2);
    send_data('1);
    set_mode(pfr_pkg::DEPTH_64, pfr_pkg::ALPHA_NONE, 1'b0, 13'd2);
    send_data('1);
    send_data(64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_width_limits();
    set_mode(pfr_pkg::DEPTH_24, pfr_pkg::ALPHA_NONE, 1'b0, 13'd0);
    send_data(rand64());
    send_data(rand64());
    set_mode(pfr_pkg::DEPTH_24, pfr_pkg::ALPHA_NONE, 1'b0, 13'h1FFF);
    send_data(rand64());
    send_data(rand64());
    // lowering the width mid row restarts the column count
    set_mode(pfr_pkg::DEPTH_24, pfr_pkg::ALPHA_NONE, 1'b0, 13'd2);
    send_data(rand64());
    send_data(rand64());
  endtask

  task automatic test_unknown_depth();
    set_mode(DEPTH_UNKNOWN, pfr_pkg::ALPHA_NONE, 1'b0, 13'd3);
    send_data(rand64());
    send_word(pfr_pkg::FUNC_PAL, rand64(), 8'h42, 24'hC3_5A17);
    send_data(rand64());
    set_mode(pfr_pkg::DEPTH_8, pfr_pkg::ALPHA_NONE, 1'b0, 13'd3);
    send_data(64'h42);
  endtask

  task automatic test_random_stream();
    logic [2:0]  depth;
    logic [12:0] width;
    logic        custom;
    int          burst;
    while (random_words < RANDOM_WORDS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      depth = ($urandom_range(0, 19) == 0) ? DEPTH_UNKNOWN : 3'($urandom_range(0, 6));
      case ($urandom_range(0, 9))
        0: width = 13'($urandom_range(25, 8191));
        1: width = 13'd0;
        default: width = 13'($urandom_range(1, 24));
      endcase
      custom = 1'($urandom_range(0, 1));
      set_mode(depth, 2'($urandom_range(0, 3)), custom, width);
      if (custom) set_masks(rand_mask(), rand_mask(), rand_mask());
      burst = $urandom_range(8, 32);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0)
          send_word(pfr_pkg::FUNC_PAL, rand64(), 8'($urandom), 24'($urandom));
        else
          send_data(rand64());
        if (depth != DEPTH_UNKNOWN) random_words++;
      end
    end
  endtask

  task automatic test_final_stream();
    idle_on = 1'b0;
    set_mode(3'($urandom_range(0, 6)), 2'($urandom_range(0, 2)), 1'b0,
             13'($urandom_range(1, 16)));
    repeat (FINAL_WORDS) send_data(rand64());
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 99) < 10) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $error("pixel word with none expected: blue %0h green %0h red %0h",
               out_blue_o, out_green_o, out_red_o);
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_blue", want.blue, out_blue_o);
        check_field("out_green", want.green, out_green_o);
        check_field("out_red", want.red, out_red_o);
        check_field("row_end", {7'd0, want.row_end}, {7'd0, row_end_o});
        check_field("last", {7'd0, want.last}, {7'd0, last_o});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("** pixel_format_to_rgb24_unit: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pfr_pkg::REG_DEPTH;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    func_i = pfr_pkg::FUNC_DATA;
    data_unit_i = '0;
    palette_index_i = '0;
    palette_color_i = '0;
    out_ready_i = 1'b0;
    col_cnt = 0;
    cur_depth = pfr_pkg::RST_DEPTH;
    cur_alpha = pfr_pkg::RST_ALPHA;
    cur_custom = pfr_pkg::RST_CUSTOM;
    cur_rmask = pfr_pkg::MASK32_R;
    cur_gmask = pfr_pkg::MASK32_G;
    cur_bmask = pfr_pkg::MASK32_B;
    cur_width = pfr_pkg::RST_WIDTH;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_palette_load();
    test_reset_state();
    test_packed_depths();
    test_mask_channels();
    test_alpha_blend();
    test_passthrough();
    test_width_limits();
    test_unknown_depth();
    test_random_stream();
    test_final_stream();
    quiesce();

    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("** pixel_format_to_rgb24_unit: PASSED **");
    end else begin
      $display("** pixel_format_to_rgb24_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/pfr_pkg.sv
src/pfr_ram.sv
src/pfr_front.sv
src/pfr_fifo.sv
src/pfr_back.sv
src/pixel_format_to_rgb24_unit.sv
sim/pixel_format_to_rgb24_unit_test.sv
